// ===== hw/rtl/ichi_pkg.sv =====
// Shared types and constants for the cloud-lines block.
package ichi_pkg;

  localparam int PRICE_W     = 32;
  localparam int LINE_W      = 34;
  localparam int INDEX_W     = 32;
  localparam int PERIOD_W    = 7;
  localparam int SHIFT_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd3;

  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 7'd9;
  localparam logic [PERIOD_W-1:0] MID_PERIOD_RST   = 7'd26;
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 7'd52;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST        = 8'd26;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } ichi_state_t;

endpackage

// ===== hw/rtl/ichimoku_cloud_lines.sv =====
// Ichimoku cloud lines: windowed high/low midpoints, scaled by four, over a candle history ring.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: candle_high, candle_low, candle_close
//          |     |                      | tuser: series_start
//  out_    | out | out_tvalid/out_tready | tdata: conversion_line, base_line, lead_a,
//          |     |                      |        lead_b, lag_close, candle_index
//          |     |                      | tuser: the five ok flags
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A candle's history walk covers P, the longest full window (1..MAX_WINDOW),
// through the single read port: one stored high/low pair per cycle through
// one shared max/min unit and one adder.
// No clearing pass: history entries are read only inside full windows.
// in_tready is low while a candle walks or while its result waits for the
// output register; cfg_ready is always high.
module ichimoku_cloud_lines #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] candle_high, [63:32] candle_low, [95:64] candle_close
  input  logic [ichi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] series_start
  input  logic [ichi_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [33:0] conversion_line, [67:34] base_line, [101:68] lead_a,
  // [135:102] lead_b, [167:136] lag_close, [199:168] candle_index
  output logic [ichi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] conversion_ok, [1] base_ok, [2] lead_a_ok, [3] lead_b_ok, [4] lag_ok
  output logic [ichi_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ichi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ichi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import ichi_pkg::*;

  localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int SW = PW + 1;
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);

  function automatic logic [CW-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [CW-1:0] r;
    if (p == '0) begin
      r = CW'(1);
    end else if (32'(p) > 32'(MAX_WINDOW)) begin
      r = CW'(MAX_WINDOW);
    end else begin
      r = CW'(p);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST_SLOT : a - AW'(1);
  endfunction

  ichi_state_t state_r, state_nxt;

  logic [PERIOD_W-1:0] sp_r, sp_nxt, mp_r, mp_nxt, lp_r, lp_nxt;
  logic [SHIFT_W-1:0]  sh_r, sh_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [INDEX_W-1:0]  seen_r, seen_nxt;
  logic [INDEX_W-1:0]  idx_r, idx_nxt;
  logic [PRICE_W-1:0]  close_r, close_nxt;
  logic                s_ok_r, s_ok_nxt, m_ok_r, m_ok_nxt, l_ok_r, l_ok_nxt;
  logic [CW-1:0]       pmax_r, pmax_nxt;
  logic [CW-1:0]       issued_r, issued_nxt, folded_r, folded_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [PW-1:0]       run_hi_r, run_hi_nxt, run_lo_r, run_lo_nxt;
  logic [SW-1:0]       s_sum_r, s_sum_nxt, m_sum_r, m_sum_nxt, l_sum_r, l_sum_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic                in_accept;
  logic [CW-1:0]       eff_s, eff_m, eff_l;
  logic [AW-1:0]       cur;
  logic [INDEX_W-1:0]  idx_in, seen_new;
  logic                ok_s, ok_m, ok_l;
  logic [CW-1:0]       p_s, p_m, p_l, p_sm;
  logic [PW-1:0]       in_hi, in_lo;
  logic [2*PW-1:0]     ram_rd;
  logic                issue;
  logic                fold_en, fold_first;
  logic [PW-1:0]       op_hi, op_lo, new_hi, new_lo;
  logic [SW-1:0]       fold_sum;
  logic [CW-1:0]       fold_cnt;
  logic [LINE_W-1:0]   conv_v, base_v, lead_a_v, lead_b_v;
  logic                a_ok, lag_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_hi = in_tdata[PW-1:0];
  assign in_lo = in_tdata[PRICE_W+PW-1:PRICE_W];

  ichi_ram #(
    .WIDTH(2 * PW),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk    (clk),
    .wr_en  (in_accept),
    .wr_addr(cur),
    .wr_data({in_lo, in_hi}),
    .rd_en  (issue),
    .rd_addr(rd_addr_r),
    .rd_data(ram_rd)
  );

  always_comb begin
    eff_s = eff_period(sp_r);
    eff_m = eff_period(mp_r);
    eff_l = eff_period(lp_r);

    cur      = in_tuser[0] ? '0 : wp_r;
    idx_in   = in_tuser[0] ? '0 : seen_r;
    seen_new = (&idx_in) ? idx_in : idx_in + INDEX_W'(1);
    ok_s     = seen_new >= INDEX_W'(eff_s);
    ok_m     = seen_new >= INDEX_W'(eff_m);
    ok_l     = seen_new >= INDEX_W'(eff_l);
    p_s      = ok_s ? eff_s : CW'(1);
    p_m      = ok_m ? eff_m : CW'(1);
    p_l      = ok_l ? eff_l : CW'(1);
    p_sm     = (p_s > p_m) ? p_s : p_m;

    // shared max/min unit and adder
    fold_first = (state_r == ST_IDLE);
    op_hi      = fold_first ? in_hi : ram_rd[PW-1:0];
    op_lo      = fold_first ? in_lo : ram_rd[2*PW-1:PW];
    new_hi     = (fold_first || op_hi > run_hi_r) ? op_hi : run_hi_r;
    new_lo     = (fold_first || op_lo < run_lo_r) ? op_lo : run_lo_r;
    fold_sum   = SW'(new_hi) + SW'(new_lo);
    fold_en    = in_accept || ((state_r == ST_WALK) && rd_vld_r);
    fold_cnt   = in_accept ? CW'(1) : folded_r + CW'(1);
    issue      = (state_r == ST_WALK) && (issued_r < pmax_r);

    a_ok     = s_ok_r && m_ok_r;
    lag_ok   = idx_r >= INDEX_W'(sh_r);
    conv_v   = s_ok_r ? (LINE_W'(s_sum_r) << 1) : '0;
    base_v   = m_ok_r ? (LINE_W'(m_sum_r) << 1) : '0;
    lead_b_v = l_ok_r ? (LINE_W'(l_sum_r) << 1) : '0;
    lead_a_v = a_ok ? (LINE_W'(s_sum_r) + LINE_W'(m_sum_r)) : '0;

    state_nxt    = state_r;
    sp_nxt       = sp_r;
    mp_nxt       = mp_r;
    lp_nxt       = lp_r;
    sh_nxt       = sh_r;
    wp_nxt       = wp_r;
    seen_nxt     = seen_r;
    idx_nxt      = idx_r;
    close_nxt    = close_r;
    s_ok_nxt     = s_ok_r;
    m_ok_nxt     = m_ok_r;
    l_ok_nxt     = l_ok_r;
    pmax_nxt     = pmax_r;
    issued_nxt   = issued_r;
    folded_nxt   = folded_r;
    rd_addr_nxt  = rd_addr_r;
    rd_vld_nxt   = issue;
    run_hi_nxt   = run_hi_r;
    run_lo_nxt   = run_lo_r;
    s_sum_nxt    = s_sum_r;
    m_sum_nxt    = m_sum_r;
    l_sum_nxt    = l_sum_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHORT_PERIOD: sp_nxt = cfg_data[PERIOD_W-1:0];
        CFG_MID_PERIOD:   mp_nxt = cfg_data[PERIOD_W-1:0];
        CFG_LONG_PERIOD:  lp_nxt = cfg_data[PERIOD_W-1:0];
        CFG_SHIFT_AMOUNT: sh_nxt = cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    if (fold_en) begin
      run_hi_nxt = new_hi;
      run_lo_nxt = new_lo;
      folded_nxt = fold_cnt;
      if (fold_cnt == eff_s) begin
        s_sum_nxt = fold_sum;
      end
      if (fold_cnt == eff_m) begin
        m_sum_nxt = fold_sum;
      end
      if (fold_cnt == eff_l) begin
        l_sum_nxt = fold_sum;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          wp_nxt      = (cur == LAST_SLOT) ? '0 : cur + AW'(1);
          seen_nxt    = seen_new;
          idx_nxt     = idx_in;
          close_nxt   = in_tdata[3*PRICE_W-1:2*PRICE_W];
          s_ok_nxt    = ok_s;
          m_ok_nxt    = ok_m;
          l_ok_nxt    = ok_l;
          pmax_nxt    = (p_sm > p_l) ? p_sm : p_l;
          issued_nxt  = CW'(1);
          rd_addr_nxt = slot_dec(cur);
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue) begin
          issued_nxt  = issued_r + CW'(1);
          rd_addr_nxt = slot_dec(rd_addr_r);
        end
        if (folded_r == pmax_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {idx_r, close_r, lead_b_v, lead_a_v, base_v, conv_v};
          out_user_nxt = {lag_ok, l_ok_r, a_ok, m_ok_r, s_ok_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= SHORT_PERIOD_RST;
      mp_r      <= MID_PERIOD_RST;
      lp_r      <= LONG_PERIOD_RST;
      sh_r      <= SHIFT_RST;
      wp_r      <= '0;
      seen_r    <= '0;
      issued_r  <= '0;
      folded_r  <= '0;
      pmax_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      sp_r      <= sp_nxt;
      mp_r      <= mp_nxt;
      lp_r      <= lp_nxt;
      sh_r      <= sh_nxt;
      wp_r      <= wp_nxt;
      seen_r    <= seen_nxt;
      issued_r  <= issued_nxt;
      folded_r  <= folded_nxt;
      pmax_r    <= pmax_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    close_r    <= close_nxt;
    s_ok_r     <= s_ok_nxt;
    m_ok_r     <= m_ok_nxt;
    l_ok_r     <= l_ok_nxt;
    rd_addr_r  <= rd_addr_nxt;
    run_hi_r   <= run_hi_nxt;
    run_lo_r   <= run_lo_nxt;
    s_sum_r    <= s_sum_nxt;
    m_sum_r    <= m_sum_nxt;
    l_sum_r    <= l_sum_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_walk_lead : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (issued_r == folded_r) || (issued_r == folded_r + CW'(1)))
    else $error("read issue count out of step with fold count");

  a_rd_pending : assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_WALK) && (folded_r < pmax_r))
    else $error("history read returned outside the window walk");

  a_accept_start : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_WALK) && (folded_r == CW'(1)) && (seen_r != '0))
    else $error("accepted candle did not start a walk");

  a_fin_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (folded_r == pmax_r) && (pmax_r <= CW'(MAX_WINDOW)))
    else $error("walk finished before covering the longest window");

endmodule

// ===== hw/rtl/ichi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ichi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/ichimoku_cloud_lines_test.sv =====
// Self-checking testbench for the Ichimoku cloud-lines block with its own line predictor.
`timescale 1ns / 1ps

module ichimoku_cloud_lines_test;
  import ichi_pkg::*;

  localparam int RING_DEPTH  = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;

  typedef struct packed {
    logic [LINE_W-1:0]  conversion;
    logic               conversion_ok;
    logic [LINE_W-1:0]  base;
    logic               base_ok;
    logic [LINE_W-1:0]  lead_a;
    logic               lead_a_ok;
    logic [LINE_W-1:0]  lead_b;
    logic               lead_b_ok;
    logic [PRICE_W-1:0] lag_close;
    logic               lag_ok;
    logic [INDEX_W-1:0] candle_idx;
  } cloud_lines_t;

  class cloud_scoreboard;
    logic [PRICE_W-1:0] high_ring [RING_DEPTH];
    logic [PRICE_W-1:0] low_ring [RING_DEPTH];
    int unsigned        wr_slot;
    logic [INDEX_W-1:0] seen;
    logic [PERIOD_W-1:0] short_len;
    logic [PERIOD_W-1:0] mid_len;
    logic [PERIOD_W-1:0] long_len;
    logic [SHIFT_W-1:0]  shift_len;
    cloud_lines_t        lines_q [$];
    int unsigned         errors;

    function new();
      foreach (high_ring[i]) begin
        high_ring[i] = '0;
        low_ring[i]  = '0;
      end
      wr_slot   = 0;
      seen      = '0;
      short_len = SHORT_PERIOD_RST;
      mid_len   = MID_PERIOD_RST;
      long_len  = LONG_PERIOD_RST;
      shift_len = SHIFT_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SHORT_PERIOD: short_len = data[PERIOD_W-1:0];
        CFG_MID_PERIOD:   mid_len   = data[PERIOD_W-1:0];
        CFG_LONG_PERIOD:  long_len  = data[PERIOD_W-1:0];
        CFG_SHIFT_AMOUNT: shift_len = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return lines_q.size();
    endfunction

    // max high plus min low over the window ending at slot cur
    function bit window_span(int unsigned cur, logic [PERIOD_W-1:0] period,
                             output logic [PRICE_W:0] span);
      int unsigned len;
      int unsigned slot;
      logic [PRICE_W-1:0] hi;
      logic [PRICE_W-1:0] lo;
      len = (period == 0) ? 1 : (period > RING_DEPTH) ? RING_DEPTH : period;
      span = '0;
      if (seen < len) return 1'b0;
      slot = cur;
      hi = '0;
      lo = '0;
      for (int unsigned k = 0; k < len; k++) begin
        if (k == 0 || high_ring[slot] > hi) hi = high_ring[slot];
        if (k == 0 || low_ring[slot] < lo) lo = low_ring[slot];
        slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
      end
      span = {1'b0, hi} + {1'b0, lo};
      return 1'b1;
    endfunction

    function void note_candle(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                              logic [PRICE_W-1:0] close, logic start);
      cloud_lines_t       want;
      int unsigned        cur;
      logic [INDEX_W-1:0] idx;
      logic [PRICE_W:0]   s_span;
      logic [PRICE_W:0]   m_span;
      logic [PRICE_W:0]   l_span;
      if (start) begin
        seen    = '0;
        wr_slot = 0;
      end
      cur = wr_slot;
      high_ring[cur] = hi;
      low_ring[cur]  = lo;
      wr_slot = (cur + 1 >= RING_DEPTH) ? 0 : cur + 1;
      idx  = seen;
      seen = (idx == '1) ? idx : idx + 1'b1;
      want.conversion_ok = window_span(cur, short_len, s_span);
      want.base_ok       = window_span(cur, mid_len, m_span);
      want.lead_b_ok     = window_span(cur, long_len, l_span);
      want.lead_a_ok     = want.conversion_ok && want.base_ok;
      want.conversion    = {s_span, 1'b0};
      want.base          = {m_span, 1'b0};
      want.lead_b        = {l_span, 1'b0};
      want.lead_a        = want.lead_a_ok ? {1'b0, s_span} + {1'b0, m_span} : '0;
      want.lag_close     = close;
      want.lag_ok        = (idx >= shift_len);
      want.candle_idx    = idx;
      lines_q.push_back(want);
    endfunction

    task report(string what, logic [LINE_W-1:0] got, logic [LINE_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      cloud_lines_t want;
      if (lines_q.size() == 0) begin
        report("result with no request pending", tdata[LINE_W-1:0], '0);
        return;
      end
      want = lines_q.pop_front();
      if (tdata[33:0] !== want.conversion) report("conversion_line", tdata[33:0], want.conversion);
      if (tdata[67:34] !== want.base) report("base_line", tdata[67:34], want.base);
      if (tdata[101:68] !== want.lead_a) report("lead_a", tdata[101:68], want.lead_a);
      if (tdata[135:102] !== want.lead_b) report("lead_b", tdata[135:102], want.lead_b);
      if (tdata[167:136] !== want.lag_close)
        report("lag_close", tdata[167:136], want.lag_close);
      if (tdata[199:168] !== want.candle_idx)
        report("candle_index", tdata[199:168], want.candle_idx);
      if (tuser[0] !== want.conversion_ok) report("conversion_ok", tuser[0], want.conversion_ok);
      if (tuser[1] !== want.base_ok) report("base_ok", tuser[1], want.base_ok);
      if (tuser[2] !== want.lead_a_ok) report("lead_a_ok", tuser[2], want.lead_a_ok);
      if (tuser[3] !== want.lead_b_ok) report("lead_b_ok", tuser[3], want.lead_b_ok);
      if (tuser[4] !== want.lag_ok) report("lag_ok", tuser[4], want.lag_ok);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cloud_scoreboard lines_sb;
  int unsigned     taken_count;
  int unsigned     quiet_cycles;

  ichimoku_cloud_lines DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void make_candle(output logic [PRICE_W-1:0] hi,
                                      output logic [PRICE_W-1:0] lo,
                                      output logic [PRICE_W-1:0] close);
    logic [PRICE_W-1:0] mid;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      mid   = $urandom;
      hi    = mid + $urandom_range(0, 4000);
      lo    = mid - $urandom_range(0, 4000);
      close = mid + $urandom_range(0, 2000) - 1000;
    end else if (r < 90) begin
      hi    = $urandom;
      lo    = $urandom;
      close = $urandom;
    end else begin
      hi    = $urandom_range(0, 1) ? '1 : $urandom;
      lo    = $urandom_range(0, 1) ? '0 : $urandom;
      close = $urandom_range(0, 1) ? '1 : '0;
    end
  endfunction

  task automatic send_candle(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                             logic [PRICE_W-1:0] close, logic start);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {close, lo, hi};
    in_tuser  = start;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    lines_sb.note_candle(hi, lo, close, start);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (lines_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lines_sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] short_val, logic [CFG_DATA_W-1:0] mid_val,
                           logic [CFG_DATA_W-1:0] long_val, logic [CFG_DATA_W-1:0] shift_val);
    drain_results();
    write_reg(CFG_SHORT_PERIOD, short_val);
    write_reg(CFG_MID_PERIOD, mid_val);
    write_reg(CFG_LONG_PERIOD, long_val);
    write_reg(CFG_SHIFT_AMOUNT, shift_val);
  endtask

  // mostly whole series of random candles, with an occasional early restart
  // unless the series length is fixed
  task automatic run_series(int unsigned count, int unsigned min_len, int unsigned max_len);
    int unsigned        left;
    logic               start;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W-1:0] close;
    left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      start = 1'b0;
      if (left == 0 || (min_len != max_len && $urandom_range(0, 49) == 0)) begin
        start = 1'b1;
        left  = $urandom_range(min_len, max_len);
      end
      left = left - 1;
      make_candle(hi, lo, close);
      send_candle(hi, lo, close, start);
    end
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && taken_count >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      lines_sb.check_result(out_tdata, out_tuser);
      taken_count <= taken_count + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    logic [PRICE_W-1:0] close;
    lines_sb     = new();
    taken_count  = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SHORT_PERIOD;
    cfg_data     = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // extremes under the reset settings, with restarts back to back
    for (int k = 0; k < 25; k++) begin
      case (k % 4)
        0: begin hi = '1; lo = '0; close = '1; end
        1: begin hi = '0; lo = '0; close = '0; end
        2: begin hi = '1; lo = '1; close = 32'hAAAA_AAAA; end
        default: begin hi = 32'h5555_5555; lo = 32'h8000_0001; close = 32'h7FFF_FFFF; end
      endcase
      send_candle(hi, lo, close, (k == 0) || (k == 13) || (k == 14));
    end

    run_series(35, 55, 70);
    drain_results();
    run_series(35, 55, 70);

    configure(8'd0, 8'd1, 8'd2, 8'd0);
    run_series(50, 1, 8);

    // long run so the lag flag turns on at the largest shift
    configure(8'd3, 8'd5, 8'h87, 8'd255);
    run_series(280, 280, 280);

    configure(8'd64, 8'd127, 8'd200, 8'd1);
    run_series(80, 64, 80);

    repeat (2) begin
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_series(30, 1, 70);
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (lines_sb.pending() != 0)
      lines_sb.report("results still outstanding", lines_sb.pending(), '0);
    if (lines_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
